### hdl/sector_cache_clock_replacement_macros.svh
// ----------------------------------------------------------------------------
// Sector cache clock replacement assertion macros
// Shared property templates for the tag and replacement engine checks.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_MACROS_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_MACROS_SVH

// same-cycle implication, held off during reset
`define SCCR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SCCR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sccr_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache clock replacement package
// Lane geometry, field widths, controller states and the result structs
// passed between the lookup, sweep and control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package sccr_pkg;

  // tags are stored and compared eight to a memory row
  localparam int LANES    = 8;
  localparam int LANE_W   = 3;
  // sector field width on the ports
  localparam int SECTOR_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MISS,
    ST_SW_RD,
    ST_SW_EVAL,
    ST_VIC_RD,
    ST_VIC_EVAL,
    ST_DONE
  } state_t;

  // outcome of comparing one tag row against the requested sector
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } match_res_t;

  // outcome of one clock sweep step over a row of accessed bits
  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
    logic [LANES-1:0]  we;
    logic [LANES-1:0]  wd;
  } sweep_res_t;

  function automatic logic [LANES-1:0] lane_onehot(input logic [LANE_W-1:0] lane);
    logic [LANES-1:0] oh;
    oh = LANES'(1) << lane;
    return oh;
  endfunction

endpackage

`default_nettype wire

### hdl/sector_cache_clock_replacement.sv
// ----------------------------------------------------------------------------
// Sector cache clock replacement engine
// Tag lookup and clock (second-chance) victim selection for a write-back
// disk sector cache; one result per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Tags and dirty bits sit in a tag
// memory and the accessed bits in a second memory, both eight slots per row
// with registered read data; a lookup reads one row per cycle over the
// R = ceil(fill_count/8) occupied rows and ends at the row of a hit; on an
// empty cache the lookup is skipped. A miss with a free slot takes the next
// free slot, and a miss in a full cache has the clock hand sweep S rows of
// accessed bits, S from 1 to ceil(NUM_SLOTS/8) + 1. A finished result waits
// while the output register still holds a stalled previous result. Slots
// fill in ascending order, so occupancy follows from the fill count and no
// clearing pass follows reset. A new request is taken while the previous
// result waits in the output register.
`default_nettype none
`include "sector_cache_clock_replacement_macros.svh"

module sector_cache_clock_replacement
  import sccr_pkg::*;
#(
  parameter int NUM_SLOTS   = 64,
  parameter int SECTOR_BITS = 32,
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [SECTOR_W-1:0] in_sector,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_hit,
  output logic [SLOT_W-1:0]        out_slot,
  output logic                     out_fill_needed,
  output logic                     out_writeback_needed,
  output logic [SECTOR_W-1:0]      out_victim_sector
);

  localparam int TAG_W  = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int ROWS   = (NUM_SLOTS + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCNT_W = ROW_W + 1;
  localparam int IDX_W  = ROW_W + LANE_W;
  localparam int FC_W   = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = ((IDX_W > FC_W) ? IDX_W : FC_W) + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  // control state
  state_t              state_r, state_nxt;
  logic [FC_W-1:0]     fill_cnt_r, fill_cnt_nxt;
  logic [SLOT_W-1:0]   hand_r, hand_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // transaction context
  logic                wr_r, wr_nxt;
  logic [TAG_W-1:0]    key_r, key_nxt;
  logic [RCNT_W-1:0]   look_row_r, look_row_nxt;
  logic [ROW_W-1:0]    pend_row_r, pend_row_nxt;
  logic                hit_r, hit_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                wb_r, wb_nxt;
  logic [TAG_W-1:0]    vsec_r, vsec_nxt;
  logic [ROW_W-1:0]    sw_row_r, sw_row_nxt;
  logic [LANE_W-1:0]   sw_start_r, sw_start_nxt;

  // output register
  logic                out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_wb_r, out_wb_nxt;
  logic [TAG_W-1:0]    out_vsec_r, out_vsec_nxt;

  // memory ports
  logic                           tag_re;
  logic [ROW_W-1:0]               tag_raddr;
  logic [LANES-1:0][TAG_W:0]      tag_rdata;
  logic [LANES-1:0]               tag_we;
  logic [ROW_W-1:0]               tag_waddr;
  logic [TAG_W:0]                 tag_wentry;
  logic [LANES-1:0][TAG_W:0]      tag_wdata;
  logic                           acc_re;
  logic [ROW_W-1:0]               acc_raddr;
  logic [LANES-1:0][0:0]          acc_rdata;
  logic [LANES-1:0]               acc_we;
  logic [ROW_W-1:0]               acc_waddr;
  logic [LANES-1:0][0:0]          acc_wdata;

  // derived values
  logic [FC_W-1:0]     fc_m1;
  logic [RCNT_W-1:0]   last_row;
  logic [IDX_W-1:0]    fill_idx;
  logic [IDX_W-1:0]    hand_idx;
  logic [IDX_W-1:0]    slot_idx;
  logic [IDX_W-1:0]    vic_idx;
  logic [SLOT_W-1:0]   vic_slot;
  logic [TAG_W:0]      vic_entry;
  logic [LANES-1:0]    look_ok;
  logic [LANES-1:0]    sw_exists;
  match_res_t          mres;
  sweep_res_t          sres;

  assign fc_m1    = fill_cnt_r - FC_W'(1);
  assign last_row = RCNT_W'(fc_m1 >> LANE_W);
  assign fill_idx = IDX_W'(fill_cnt_r);
  assign hand_idx = IDX_W'(hand_r);
  assign slot_idx = IDX_W'(slot_r);
  assign vic_idx  = {sw_row_r, sres.lane};
  assign vic_slot = SLOT_W'(vic_idx);
  assign vic_entry = tag_rdata[slot_idx[LANE_W-1:0]];
  assign tag_wdata = {LANES{tag_wentry}};

  // per-lane occupancy of the row under lookup and existence in the swept row
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign look_ok[g]   = CMP_W'({pend_row_r, LANE_W'(g)}) < CMP_W'(fill_cnt_r);
    assign sw_exists[g] = CMP_W'({sw_row_r, LANE_W'(g)}) < CMP_W'(NUM_SLOTS);
  end

  // tag and dirty store
  sccr_lane_mem #(
    .ROWS   (ROWS),
    .ADDR_W (ROW_W),
    .DW     (TAG_W + 1)
  ) u_tag_mem (
    .clk     (clk),
    .rd_en   (tag_re),
    .rd_addr (tag_raddr),
    .rd_data (tag_rdata),
    .wr_en   (tag_we),
    .wr_addr (tag_waddr),
    .wr_data (tag_wdata)
  );

  // accessed-bit store
  sccr_lane_mem #(
    .ROWS   (ROWS),
    .ADDR_W (ROW_W),
    .DW     (1)
  ) u_acc_mem (
    .clk     (clk),
    .rd_en   (acc_re),
    .rd_addr (acc_raddr),
    .rd_data (acc_rdata),
    .wr_en   (acc_we),
    .wr_addr (acc_waddr),
    .wr_data (acc_wdata)
  );

  sccr_tag_match #(
    .TAG_W (TAG_W)
  ) u_match (
    .row     (tag_rdata),
    .key     (key_r),
    .lane_ok (look_ok),
    .res     (mres)
  );

  sccr_sweep_step u_sweep (
    .acc    (acc_rdata),
    .exists (sw_exists),
    .start  (sw_start_r),
    .res    (sres)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= '0;
      hand_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      hand_r      <= hand_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction context and output payload
  always_ff @(posedge clk) begin
    wr_r       <= wr_nxt;
    key_r      <= key_nxt;
    look_row_r <= look_row_nxt;
    pend_row_r <= pend_row_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    wb_r       <= wb_nxt;
    vsec_r     <= vsec_nxt;
    sw_row_r   <= sw_row_nxt;
    sw_start_r <= sw_start_nxt;
    out_hit_r  <= out_hit_nxt;
    out_slot_r <= out_slot_nxt;
    out_wb_r   <= out_wb_nxt;
    out_vsec_r <= out_vsec_nxt;
  end

  // next state, memory control and result assembly
  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    hand_nxt      = hand_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    wr_nxt        = wr_r;
    key_nxt       = key_r;
    look_row_nxt  = look_row_r;
    pend_row_nxt  = pend_row_r;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    wb_nxt        = wb_r;
    vsec_nxt      = vsec_r;
    sw_row_nxt    = sw_row_r;
    sw_start_nxt  = sw_start_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_wb_nxt    = out_wb_r;
    out_vsec_nxt  = out_vsec_r;
    tag_re        = 1'b0;
    tag_raddr     = look_row_r[ROW_W-1:0];
    tag_we        = '0;
    tag_waddr     = pend_row_r;
    tag_wentry    = {wr_r, key_r};
    acc_re        = 1'b0;
    acc_raddr     = sw_row_r;
    acc_we        = '0;
    acc_waddr     = pend_row_r;
    acc_wdata     = '1;

    case (state_r)
      // take a request
      ST_IDLE: begin
        if (in_valid) begin
          wr_nxt       = in_req_type;
          key_nxt      = in_sector[TAG_W-1:0];
          look_row_nxt = '0;
          hit_nxt      = 1'b0;
          wb_nxt       = 1'b0;
          vsec_nxt     = '0;
          state_nxt    = (fill_cnt_r == '0) ? ST_MISS : ST_LOOK;
        end
      end

      // stream occupied tag rows, compare each one in the cycle after its read
      ST_LOOK: begin
        if (look_row_r <= last_row) begin
          tag_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_row_nxt = look_row_r[ROW_W-1:0];
          look_row_nxt = look_row_r + RCNT_W'(1);
        end
        if (pend_r) begin
          if (mres.hit) begin
            hit_nxt    = 1'b1;
            slot_nxt   = SLOT_W'({pend_row_r, mres.lane});
            tag_wentry = {1'b1, key_r};
            tag_we     = wr_r ? lane_onehot(mres.lane) : '0;
            acc_we     = lane_onehot(mres.lane);
            pend_nxt   = 1'b0;
            state_nxt  = ST_DONE;
          end else if (RCNT_W'(pend_row_r) == last_row) begin
            state_nxt = ST_MISS;
          end
        end
      end

      // fill the next free slot, or start the clock sweep when full
      ST_MISS: begin
        if (fill_cnt_r < FC_W'(NUM_SLOTS)) begin
          slot_nxt     = SLOT_W'(fill_cnt_r);
          tag_waddr    = fill_idx[IDX_W-1:LANE_W];
          tag_we       = lane_onehot(fill_idx[LANE_W-1:0]);
          acc_waddr    = fill_idx[IDX_W-1:LANE_W];
          acc_we       = lane_onehot(fill_idx[LANE_W-1:0]);
          fill_cnt_nxt = fill_cnt_r + FC_W'(1);
          state_nxt    = ST_DONE;
        end else begin
          sw_row_nxt   = hand_idx[IDX_W-1:LANE_W];
          sw_start_nxt = hand_idx[LANE_W-1:0];
          state_nxt    = ST_SW_RD;
        end
      end

      ST_SW_RD: begin
        acc_re    = 1'b1;
        state_nxt = ST_SW_EVAL;
      end

      // clear passed-over bits in this row, stop at the first clear bit
      ST_SW_EVAL: begin
        acc_waddr = sw_row_r;
        acc_we    = sres.we;
        acc_wdata = sres.wd;
        if (sres.found) begin
          slot_nxt  = vic_slot;
          hand_nxt  = (vic_slot == SLOT_LAST) ? '0 : vic_slot + SLOT_W'(1);
          state_nxt = ST_VIC_RD;
        end else begin
          sw_row_nxt   = (sw_row_r == ROW_LAST) ? '0 : sw_row_r + ROW_W'(1);
          sw_start_nxt = '0;
          state_nxt    = ST_SW_RD;
        end
      end

      ST_VIC_RD: begin
        tag_re    = 1'b1;
        tag_raddr = slot_idx[IDX_W-1:LANE_W];
        state_nxt = ST_VIC_EVAL;
      end

      // report a dirty victim and replace its tag in place
      ST_VIC_EVAL: begin
        wb_nxt    = vic_entry[TAG_W];
        vsec_nxt  = vic_entry[TAG_W] ? vic_entry[TAG_W-1:0] : '0;
        tag_waddr = slot_idx[IDX_W-1:LANE_W];
        tag_we    = lane_onehot(slot_idx[LANE_W-1:0]);
        state_nxt = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_slot_nxt  = slot_r;
          out_wb_nxt    = wb_r;
          out_vsec_nxt  = vsec_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ports
  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_slot             = out_slot_r;
  assign out_fill_needed      = !out_hit_r;
  assign out_writeback_needed = out_wb_r;
  assign out_victim_sector    = SECTOR_W'(out_vsec_r);

  // checks
  `SCCR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_cnt_r <= FC_W'(NUM_SLOTS),
    "fill count beyond slot count")
  `SCCR_ASSERT_IMP(a_hand_range, clk, rst_n, 1'b1, hand_r <= SLOT_LAST,
    "clock hand out of range")
  `SCCR_ASSERT_IMP(a_sweep_full, clk, rst_n,
    (state_r == ST_SW_RD) || (state_r == ST_SW_EVAL), fill_cnt_r == FC_W'(NUM_SLOTS),
    "clock sweep while free slots remain")
  `SCCR_ASSERT_NXT(a_fill_step, clk, rst_n,
    (state_r == ST_MISS) && (fill_cnt_r < FC_W'(NUM_SLOTS)),
    fill_cnt_r == $past(fill_cnt_r) + FC_W'(1),
    "free-slot fill did not advance fill count")
  `SCCR_ASSERT_IMP(a_wb_on_miss, clk, rst_n, out_valid_r && out_wb_r, !out_hit_r,
    "write-back reported on a hit")
  `SCCR_ASSERT_IMP(a_vsec_zero, clk, rst_n, out_valid_r && !out_wb_r, out_vsec_r == '0,
    "victim sector set without write-back")

endmodule

`default_nettype wire

### hdl/sccr_lane_mem.sv
// ----------------------------------------------------------------------------
// Sector cache lane memory
// Synchronous single-read, single-write memory of rows of lane entries,
// with a write enable per lane and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_lane_mem
  import sccr_pkg::*;
#(
  parameter int ROWS   = 8,
  parameter int ADDR_W = 3,
  parameter int DW     = 33
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [LANES-1:0][DW-1:0]   rd_data,
  input  wire logic [LANES-1:0]           wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [LANES-1:0][DW-1:0]   wr_data
);

  logic [LANES-1:0][DW-1:0] mem_r [ROWS];
  logic [LANES-1:0][DW-1:0] rd_data_r;

  // lane-masked write
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (wr_en[i]) begin
        mem_r[wr_addr][i] <= wr_data[i];
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/sccr_tag_match.sv
// ----------------------------------------------------------------------------
// Sector cache tag match
// Compares one row of stored tags with the requested sector and returns the
// lowest occupied lane that holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_tag_match
  import sccr_pkg::*;
#(
  parameter int TAG_W = 32
) (
  input  wire logic [LANES-1:0][TAG_W:0] row,
  input  wire logic [TAG_W-1:0]          key,
  input  wire logic [LANES-1:0]          lane_ok,
  output match_res_t                     res
);

  // priority pick of the lowest matching lane
  always_comb begin
    res = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!res.hit && lane_ok[i] && (row[i][TAG_W-1:0] == key)) begin
        res.hit  = 1'b1;
        res.lane = LANE_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/sccr_sweep_step.sv
// ----------------------------------------------------------------------------
// Sector cache sweep step
// One row of the clock sweep: from the start lane upward, finds the first
// slot whose accessed bit is clear and gives the bits to write back.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_sweep_step
  import sccr_pkg::*;
(
  input  wire logic [LANES-1:0]  acc,
  input  wire logic [LANES-1:0]  exists,
  input  wire logic [LANE_W-1:0] start,
  output sweep_res_t             res
);

  // first candidate at or after the start lane
  always_comb begin
    res = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!res.found && exists[i] && (LANE_W'(i) >= start) && !acc[i]) begin
        res.found = 1'b1;
        res.lane  = LANE_W'(i);
      end
    end
    // clear passed-over bits, set the bit of the victim slot
    for (int i = 0; i < LANES; i++) begin
      res.we[i] = exists[i] && (LANE_W'(i) >= start) && (!res.found || (LANE_W'(i) <= res.lane));
    end
    res.wd = res.found ? lane_onehot(res.lane) : '0;
  end

endmodule

`default_nettype wire
